[rtl/key_value_token_splitter_assert.svh]
// Assertion macros shared by the checker of the key/value token splitter.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef KEY_VALUE_TOKEN_SPLITTER_ASSERT_SVH
`define KEY_VALUE_TOKEN_SPLITTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define KVTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define KVTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[rtl/kvts_pkg.sv]
// Types and character constants of the key/value token splitter.
// No dependencies; used by all modules and the checker.
package kvts_pkg;

  // Characters the splitter reacts to
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Most results one input byte can cause
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_SEP   = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_EQ   = 3'd1,
    OP_LT   = 3'd2,
    OP_LE   = 3'd3,
    OP_GT   = 3'd4,
    OP_GE   = 3'd5,
    OP_NE   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_LT   = 2'd1,
    HOLD_GT   = 2'd2,
    HOLD_BANG = 2'd3
  } hold_e;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  // One result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    op_e        opc;
    logic       kempty;
  } result_t;

  // All results of one input byte, in order
  typedef struct packed {
    logic [1:0]                 count;
    result_t [MaxResults-1:0]   res;
  } bundle_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[rtl/kvts_in_if.sv]
// Input channel of the key/value token splitter: one line byte per transaction.
// No dependencies.
interface kvts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_line;

  modport source (output valid, output data_byte, output end_of_line, input ready);
  modport sink (input valid, input data_byte, input end_of_line, output ready);
endinterface

[rtl/kvts_cfg_if.sv]
// Configuration write channel of the key/value token splitter.
// No dependencies.
interface kvts_cfg_if;
  logic valid;
  logic ready;
  logic operator_mode;

  modport source (output valid, output operator_mode, input ready);
  modport sink (input valid, input operator_mode, output ready);
endinterface

[rtl/kvts_out_if.sv]
// Result channel of the key/value token splitter: one result item per transaction.
// No dependencies.
interface kvts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] operator_code;
  logic       key_empty;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output operator_code,
                  output key_empty, output last_of_run, input ready);
  modport sink (input valid, input kind, input out_byte, input operator_code,
                input key_empty, input last_of_run, output ready);
endinterface

[rtl/kvts_fifo.sv]
// Short queue of result bundles between the front and the back.
// Depends on kvts_pkg.
module kvts_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  kvts_pkg::bundle_t       data_i,
  input  logic                    pop_i,
  output kvts_pkg::bundle_t       data_o,
  output kvts_pkg::fifo_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  kvts_pkg::bundle_t entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed bundle
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);

endmodule

[rtl/kvts_front.sv]
// Front of the splitter: accepts line bytes, tracks quote/pair state and
// builds the bundle of results each byte causes. Depends on kvts_pkg, kvts_in_if,
// kvts_cfg_if.
module kvts_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  kvts_in_if.sink                in_i,
  kvts_cfg_if.sink               cfg_i,
  input  kvts_pkg::fifo_status_t status_i,
  output logic                   push_o,
  output kvts_pkg::bundle_t      bundle_o
);

  logic              mode_q;
  kvts_pkg::quote_e  quote_q, quote_d;
  logic              key_seen_q, key_seen_d;
  logic              tok_ne_q, tok_ne_d;
  logic              key_ne_q, key_ne_d;
  logic              started_q, started_d;
  kvts_pkg::hold_e   hold_q, hold_d;
  logic              bslash_q, bslash_d;
  kvts_pkg::op_e     oper_q, oper_d;
  logic              accept;

  assign in_i.ready  = !status_i.full;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  // Work out the next state and the results of this byte
  always_comb begin
    logic [7:0]                           b;
    logic [1:0]                           n;
    kvts_pkg::result_t [kvts_pkg::MaxResults-1:0] res;
    kvts_pkg::hold_e                      held;
    kvts_pkg::quote_e                     qcode;
    logic                                 consumed;
    logic                                 done;
    logic                                 is_quote;

    b          = in_i.data_byte;
    n          = '0;
    res        = '0;
    held       = hold_q;
    consumed   = 1'b0;
    done       = 1'b0;
    quote_d    = quote_q;
    key_seen_d = key_seen_q;
    tok_ne_d   = tok_ne_q;
    key_ne_d   = key_ne_q;
    started_d  = started_q;
    hold_d     = kvts_pkg::HOLD_NONE;
    oper_d     = oper_q;
    is_quote   = ((b == kvts_pkg::CH_DQUOTE) || (b == kvts_pkg::CH_SQUOTE)) && !bslash_q;
    qcode      = (b == kvts_pkg::CH_DQUOTE) ? kvts_pkg::QUOTE_DOUBLE : kvts_pkg::QUOTE_SINGLE;

    // Resolve a symbol held from the previous byte
    if (held == kvts_pkg::HOLD_BANG) begin
      if (b == kvts_pkg::CH_EQ) begin
        key_ne_d   = tok_ne_d;
        tok_ne_d   = 1'b0;
        key_seen_d = 1'b1;
        oper_d     = kvts_pkg::OP_NE;
        started_d  = 1'b1;
        res[n]     = '{kind: kvts_pkg::KIND_SEP, data: '0, opc: kvts_pkg::OP_NONE,
                       kempty: 1'b0};
        n          = n + 2'd1;
        consumed   = 1'b1;
      end else begin
        res[n]    = '{kind: key_seen_d ? kvts_pkg::KIND_VALUE : kvts_pkg::KIND_KEY,
                      data: kvts_pkg::CH_BANG, opc: kvts_pkg::OP_NONE, kempty: 1'b0};
        n         = n + 2'd1;
        tok_ne_d  = 1'b1;
        started_d = 1'b1;
      end
    end else if ((held == kvts_pkg::HOLD_LT) || (held == kvts_pkg::HOLD_GT)) begin
      if (b == kvts_pkg::CH_EQ) begin
        oper_d   = (held == kvts_pkg::HOLD_LT) ? kvts_pkg::OP_LE : kvts_pkg::OP_GE;
        consumed = 1'b1;
      end
    end

    if (!consumed) begin
      // Open or close a quoted run
      if (is_quote && (quote_d == kvts_pkg::QUOTE_NONE)) begin
        quote_d   = qcode;
        started_d = 1'b1;
        done      = 1'b1;
      end else if (is_quote && (quote_d == qcode)) begin
        quote_d = kvts_pkg::QUOTE_NONE;
        if (key_seen_d) begin
          res[n]     = '{kind: kvts_pkg::KIND_END, data: '0, opc: oper_d,
                         kempty: key_seen_d ? !key_ne_d : !tok_ne_d};
          n          = n + 2'd1;
          key_seen_d = 1'b0;
          tok_ne_d   = 1'b0;
          key_ne_d   = 1'b0;
          started_d  = 1'b0;
          hold_d     = kvts_pkg::HOLD_NONE;
          oper_d     = kvts_pkg::OP_NONE;
        end else begin
          started_d = 1'b1;
        end
        done = 1'b1;
      end

      // Separators, spaces and a bang outside a quote
      if (!done && (quote_d == kvts_pkg::QUOTE_NONE)) begin
        if (b == kvts_pkg::CH_EQ ||
            (mode_q && ((b == kvts_pkg::CH_LT) || (b == kvts_pkg::CH_GT)))) begin
          key_ne_d   = tok_ne_d;
          tok_ne_d   = 1'b0;
          key_seen_d = 1'b1;
          started_d  = 1'b1;
          res[n]     = '{kind: kvts_pkg::KIND_SEP, data: '0, opc: kvts_pkg::OP_NONE,
                         kempty: 1'b0};
          n          = n + 2'd1;
          if (b == kvts_pkg::CH_EQ) begin
            oper_d = kvts_pkg::OP_EQ;
          end else if (b == kvts_pkg::CH_LT) begin
            oper_d = kvts_pkg::OP_LT;
            hold_d = kvts_pkg::HOLD_LT;
          end else begin
            oper_d = kvts_pkg::OP_GT;
            hold_d = kvts_pkg::HOLD_GT;
          end
          done = 1'b1;
        end else if (b == kvts_pkg::CH_SPACE) begin
          if (tok_ne_d && key_seen_d) begin
            res[n]     = '{kind: kvts_pkg::KIND_END, data: '0, opc: oper_d,
                           kempty: !key_ne_d};
            n          = n + 2'd1;
            quote_d    = kvts_pkg::QUOTE_NONE;
            key_seen_d = 1'b0;
            tok_ne_d   = 1'b0;
            key_ne_d   = 1'b0;
            started_d  = 1'b0;
            hold_d     = kvts_pkg::HOLD_NONE;
            oper_d     = kvts_pkg::OP_NONE;
          end else begin
            started_d = 1'b1;
          end
          done = 1'b1;
        end else if (mode_q && (b == kvts_pkg::CH_BANG)) begin
          hold_d    = kvts_pkg::HOLD_BANG;
          started_d = 1'b1;
          done      = 1'b1;
        end
      end

      // Plain text byte
      if (!done) begin
        res[n]    = '{kind: key_seen_d ? kvts_pkg::KIND_VALUE : kvts_pkg::KIND_KEY,
                      data: b, opc: kvts_pkg::OP_NONE, kempty: 1'b0};
        n         = n + 2'd1;
        tok_ne_d  = 1'b1;
        started_d = 1'b1;
      end
    end

    bslash_d = (b == kvts_pkg::CH_BSLASH);

    // Close the line: flush a held bang, end an open pair, clear all
    if (in_i.end_of_line) begin
      if (hold_d == kvts_pkg::HOLD_BANG) begin
        res[n]    = '{kind: key_seen_d ? kvts_pkg::KIND_VALUE : kvts_pkg::KIND_KEY,
                      data: kvts_pkg::CH_BANG, opc: kvts_pkg::OP_NONE, kempty: 1'b0};
        n         = n + 2'd1;
        tok_ne_d  = 1'b1;
        started_d = 1'b1;
      end
      if (started_d) begin
        res[n] = '{kind: kvts_pkg::KIND_END, data: '0, opc: oper_d,
                   kempty: key_seen_d ? !key_ne_d : !tok_ne_d};
        n      = n + 2'd1;
      end
      quote_d    = kvts_pkg::QUOTE_NONE;
      key_seen_d = 1'b0;
      tok_ne_d   = 1'b0;
      key_ne_d   = 1'b0;
      started_d  = 1'b0;
      hold_d     = kvts_pkg::HOLD_NONE;
      bslash_d   = 1'b0;
      oper_d     = kvts_pkg::OP_NONE;
    end

    bundle_o.count = n;
    bundle_o.res   = res;
    push_o         = accept && (n != 2'd0);
  end

  // Hold line state, advance on each accepted byte; take operator_mode on a config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      quote_q    <= kvts_pkg::QUOTE_NONE;
      key_seen_q <= 1'b0;
      tok_ne_q   <= 1'b0;
      key_ne_q   <= 1'b0;
      started_q  <= 1'b0;
      hold_q     <= kvts_pkg::HOLD_NONE;
      bslash_q   <= 1'b0;
      oper_q     <= kvts_pkg::OP_NONE;
    end else begin
      if (cfg_i.valid) begin
        mode_q <= cfg_i.operator_mode;
      end
      if (accept) begin
        quote_q    <= quote_d;
        key_seen_q <= key_seen_d;
        tok_ne_q   <= tok_ne_d;
        key_ne_q   <= key_ne_d;
        started_q  <= started_d;
        hold_q     <= hold_d;
        bslash_q   <= bslash_d;
        oper_q     <= oper_d;
      end
    end
  end

endmodule

[rtl/kvts_back.sv]
// Back of the splitter: walks the results of the queue head bundle and drives
// them one per transaction through an output register. Depends on kvts_pkg, kvts_out_if.
module kvts_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kvts_pkg::bundle_t      head_i,
  input  kvts_pkg::fifo_status_t status_i,
  output logic                   pop_o,
  kvts_out_if.source             out_o
);

  logic [1:0]         idx_q, idx_d;
  logic               valid_q, valid_d;
  kvts_pkg::result_t  res_q;
  logic               last_q;
  kvts_pkg::result_t  cur;
  logic               is_last;
  logic               load;

  assign cur     = head_i.res[idx_q];
  assign is_last = (idx_q == (head_i.count - 2'd1));
  assign load    = !status_i.empty && (!valid_q || out_o.ready);
  assign pop_o   = load && is_last;

  // Step through the bundle, drop the output once taken
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= cur;
      last_q <= is_last;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.out_byte      = res_q.data;
  assign out_o.operator_code = res_q.opc;
  assign out_o.key_empty     = res_q.kempty;
  assign out_o.last_of_run   = last_q;

endmodule

[rtl/key_value_token_splitter.sv]
// Top level of the key/value token splitter: front, bundle queue and back.
// Depends on kvts_pkg, the three channel interfaces, kvts_front, kvts_fifo, kvts_back.
//
// Usage:
//   in_i  : one byte of an attribute line per transaction, end_of_line set on
//           the last byte of the line.
//   cfg_i : writes operator_mode; write it only while the block is idle.
//   out_o : result items (key char, value char, separator, pair end), each
//           byte's results in order, last_of_run set on the last one.
// Path: a byte's results are written into the bundle queue and then loaded one
//   at a time into the output register that drives out_o; later results of the
//   same byte follow one per cycle while out_o.ready stays high.
// Throughput: one input byte per cycle while each byte causes at most one
//   result and out_o.ready stays high; a byte with several results holds the
//   output register until all are out, one result per cycle while out_o.ready
//   is high. Bytes with no result pass without using the output.
// Stalls: when out_o.ready is low the output register holds, the queue of
//   QueueDepth bundles fills, and in_i.ready drops only once it is full.
// Reset: clears operator_mode, the line state and the queue; nothing is
//   pending after reset.
module key_value_token_splitter #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kvts_in_if.sink     in_i,
  kvts_cfg_if.sink    cfg_i,
  kvts_out_if.source  out_o
);

  logic                   push;
  logic                   pop;
  kvts_pkg::bundle_t      push_bundle;
  kvts_pkg::bundle_t      head_bundle;
  kvts_pkg::fifo_status_t fifo_status;

  // Classify bytes and build result bundles
  kvts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .status_i (fifo_status),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  // Decouple front and back
  kvts_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_bundle),
    .pop_i    (pop),
    .data_o   (head_bundle),
    .status_o (fifo_status)
  );

  // Emit results one per transaction
  kvts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_bundle),
    .status_i (fifo_status),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

[rtl/kvts_checker.sv]
// Port-level checks of the key/value token splitter, bound to its top level.
// Depends on kvts_pkg and key_value_token_splitter_assert.svh.
`include "key_value_token_splitter_assert.svh"

module kvts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [2:0] out_opc,
  input logic       out_kempty,
  input logic       out_last
);

  logic [14:0] out_bus;
  logic        stalled;
  logic        is_end;
  logic        is_char;
  logic        no_end_info;

  // Gather the result payload and classify the result kind
  assign out_bus     = {out_kind, out_byte, out_opc, out_kempty, out_last};
  assign stalled     = out_valid && !out_ready;
  assign is_end      = (out_kind == kvts_pkg::KIND_END);
  assign is_char     = (out_kind == kvts_pkg::KIND_KEY) || (out_kind == kvts_pkg::KIND_VALUE);
  assign no_end_info = (out_opc == kvts_pkg::OP_NONE) && !out_kempty;

  // A stalled result holds its value
  `KVTS_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_bus), "held result changed")

  // Only a pair end carries operator and empty-key flag
  `KVTS_ASSERT(a_end_fields, !out_valid || is_end || no_end_info, "pair-end field on other kind")

  // Separators and pair ends carry no character
  `KVTS_ASSERT(a_no_byte, !out_valid || is_char || (out_byte == 8'd0), "byte on sep or pair end")

  // Operator codes stay in range
  `KVTS_ASSERT(a_opc_range, !out_valid || (out_opc <= kvts_pkg::OP_NE), "undefined operator code")

endmodule

bind key_value_token_splitter kvts_checker u_kvts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_kind   (out_o.kind),
  .out_byte   (out_o.out_byte),
  .out_opc    (out_o.operator_code),
  .out_kempty (out_o.key_empty),
  .out_last   (out_o.last_of_run)
);
